// ===== src/cpf_pkg.sv =====
// Shared types and constants for the command packet framer.
// Holds the item structs, action codes and the queued command format.
// No dependencies.
package cpf_pkg;

  localparam logic [1:0] ACT_OPEN  = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  localparam logic [15:0] HEADER_RESET  = 16'hEF01;
  localparam logic [31:0] ADDRESS_RESET = 32'hFFFF_FFFF;

  localparam logic CFG_IDX_HEADER  = 1'b0;
  localparam logic CFG_IDX_ADDRESS = 1'b1;

  localparam int CFG_DATA_W = 32;

  localparam logic [3:0] OPEN_LAST_IDX  = 4'd9;
  localparam logic [3:0] DATA_LAST_IDX  = 4'd0;
  localparam logic [3:0] CLOSE_LAST_IDX = 4'd3;

  localparam int CPF_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  packet_id;
    logic [15:0] packet_length;
    logic [7:0]  instruction;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

  // One queued command: for data the byte rides in id_byte, for close the
  // sum rides in word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  id_byte;
    logic [15:0] word;
    logic [7:0]  instr;
  } cpf_cmd_t;

endpackage

// ===== src/cpf_front.sv =====
// Front end: accepts input items, tracks the open packet and running sum,
// and queues opens and data/closes of an open packet. Depends on cpf_pkg.
module cpf_front
  import cpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output cpf_cmd_t q_cmd
);

  logic        open_r, open_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    open_nxt      = open_r;
    sum_nxt       = sum_r;
    q_push        = 1'b0;
    q_cmd.kind    = in_item.action;
    q_cmd.id_byte = in_item.packet_id;
    q_cmd.word    = in_item.packet_length;
    q_cmd.instr   = in_item.instruction;
    if (accept) begin
      unique case (in_item.action)
        ACT_OPEN: begin
          q_push   = 1'b1;
          open_nxt = 1'b1;
          sum_nxt  = {8'd0, in_item.packet_id} + in_item.packet_length
                     + {8'd0, in_item.instruction};
        end
        ACT_DATA: begin
          q_push        = open_r;
          q_cmd.id_byte = in_item.data_byte;
          if (open_r) begin
            sum_nxt = sum_r + {8'd0, in_item.data_byte};
          end
        end
        ACT_CLOSE: begin
          q_push     = open_r;
          q_cmd.word = sum_r;
          open_nxt   = 1'b0;
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      sum_r  <= 16'd0;
    end else begin
      open_r <= open_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

// ===== src/cpf_queue.sv =====
// Small command queue between the front and back ends.
// Depends on cpf_pkg for the command type.
module cpf_queue
  import cpf_pkg::*;
#(
  parameter int Depth = CPF_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cpf_cmd_t push_cmd,
  input  logic     pop,
  output cpf_cmd_t head_cmd,
  output logic     empty,
  output logic     full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  cpf_cmd_t        mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == DepthCnt);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DepthCnt)
    else $error("queue count exceeds depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

endmodule

// ===== src/cpf_back.sv =====
// Back end: takes commands from the queue and serializes them byte by
// byte into the output register. Depends on cpf_pkg.
module cpf_back
  import cpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] header_word,
  input  logic [31:0] device_address,
  input  cpf_cmd_t    head_cmd,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  cpf_cmd_t   cmd_r;
  logic       busy_r, busy_nxt;
  logic [3:0] idx_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;
  logic       adv;
  logic       at_last;
  logic [3:0] last_idx;
  out_item_t  cur_byte;

  always_comb begin
    unique case (cmd_r.kind)
      ACT_OPEN:  last_idx = OPEN_LAST_IDX;
      ACT_CLOSE: last_idx = CLOSE_LAST_IDX;
      default:   last_idx = DATA_LAST_IDX;
    endcase
  end

  always_comb begin
    cur_byte.last_byte = 1'b0;
    cur_byte.frame_byte = cmd_r.id_byte;
    if (cmd_r.kind == ACT_OPEN) begin
      unique case (idx_r)
        4'd0:    cur_byte.frame_byte = header_word[15:8];
        4'd1:    cur_byte.frame_byte = header_word[7:0];
        4'd2:    cur_byte.frame_byte = device_address[31:24];
        4'd3:    cur_byte.frame_byte = device_address[23:16];
        4'd4:    cur_byte.frame_byte = device_address[15:8];
        4'd5:    cur_byte.frame_byte = device_address[7:0];
        4'd6:    cur_byte.frame_byte = cmd_r.id_byte;
        4'd7:    cur_byte.frame_byte = cmd_r.word[15:8];
        4'd8:    cur_byte.frame_byte = cmd_r.word[7:0];
        default: cur_byte.frame_byte = cmd_r.instr;
      endcase
    end else if (cmd_r.kind == ACT_CLOSE) begin
      unique case (idx_r[1:0])
        2'd0: cur_byte.frame_byte = cmd_r.word[15:8];
        2'd1: cur_byte.frame_byte = cmd_r.word[7:0];
        2'd2: cur_byte.frame_byte = BYTE_CR;
        2'd3: begin
          cur_byte.frame_byte = BYTE_LF;
          cur_byte.last_byte  = 1'b1;
        end
        default: cur_byte.frame_byte = BYTE_LF;
      endcase
    end
  end

  assign adv     = busy_r && (!out_valid_r || !out_stall);
  assign at_last = (idx_r == last_idx);
  assign q_pop   = !q_empty && (!busy_r || (adv && at_last));

  always_comb begin
    busy_nxt = busy_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
    end else if (adv && at_last) begin
      busy_nxt = 1'b0;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= head_cmd;
    end
    if (adv) begin
      out_item_r <= cur_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        idx_r <= 4'd0;
      end else if (adv && !at_last) begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= last_idx)
    else $error("byte index past end of command");

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last_byte) |-> out_item_r.frame_byte == BYTE_LF)
    else $error("last byte flag on a byte other than line feed");

  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && busy_r) |-> (adv && at_last))
    else $error("new command loaded over an unfinished one");

endmodule

// ===== src/command_packet_framer.sv =====
// Command packet framer: an item passes the command queue, the back end's
// command register and the output register. The back end emits one byte
// per cycle while busy and not stalled: an open item gives ten bytes, a
// data item one, a close item four. The command queue lets input items keep
// arriving while bytes drain. Reset is synchronous, active low: no packet
// open, sum zero, queue empty, header 0xEF01 and address 0xFFFFFFFF.
module command_packet_framer
  import cpf_pkg::*;
#(
  parameter int QUEUE_DEPTH = CPF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  logic [15:0] header_r;
  logic [31:0] address_r;
  logic        q_full, q_empty, q_push, q_pop;
  cpf_cmd_t    push_cmd, head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_RESET;
      address_r <= ADDRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_HEADER:  header_r  <= cfg_data[15:0];
        CFG_IDX_ADDRESS: address_r <= cfg_data[31:0];
        default:         header_r  <= header_r;
      endcase
    end
  end

  cpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  cpf_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  cpf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .header_word    (header_r),
    .device_address (address_r),
    .head_cmd       (head_cmd),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

endmodule
